@@ design/kmst_pkg.sv @@
package kmst_pkg;

   localparam int MAX_VERTICES  = 64;
   localparam int VERT_BITS     = $clog2(MAX_VERTICES);
   localparam int VC_BITS       = 7;
   localparam int WEIGHT_BITS   = 16;
   localparam int TOTAL_BITS    = 22;
   localparam int RANK_BITS     = 3;
   localparam int DEF_MAX_EDGES = 256;
   localparam int REQ_DATA_BITS = 32;
   localparam int RSP_DATA_BITS = 56;

   typedef logic [VERT_BITS-1:0] vert_type;

   // from_vtx sits in the lowest bits
   typedef struct packed {
      logic signed [WEIGHT_BITS-1:0] weight;
      vert_type                      to_vtx;
      vert_type                      from_vtx;
   } edge_type;

   typedef struct packed {
      logic     start;
      logic     clear;
      vert_type a;
      vert_type b;
   } dsu_req_type;

   typedef struct packed {
      logic done;
      logic joined;
   } dsu_rsp_type;

   typedef struct packed {
      logic wr_en;
      logic sort_start;
   } est_ctl_type;

   typedef struct packed {
      logic sort_done;
   } est_sts_type;

endpackage

@@ design/kmst_estore.sv @@
module kmst_estore #(
   parameter int MAX_EDGES = kmst_pkg::DEF_MAX_EDGES,
   localparam int IW = $clog2(MAX_EDGES),
   localparam int CW = $clog2(MAX_EDGES + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  kmst_pkg::est_ctl_type  ctl,
   input  logic [IW-1:0]          wr_addr,
   input  kmst_pkg::edge_type     wr_data,
   input  logic [IW-1:0]          rd_addr,
   input  logic [CW-1:0]          fill,
   output kmst_pkg::edge_type     rd_data,
   output kmst_pkg::est_sts_type  sts
);
   import kmst_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RDI   = 3'd1;
   localparam logic [2:0] ST_GETI  = 3'd2;
   localparam logic [2:0] ST_CMP   = 3'd3;
   localparam logic [2:0] ST_PLACE = 3'd4;

   edge_type mem [MAX_EDGES];

   logic [2:0]    st_ff, st_in;
   logic [CW-1:0] i_ff, i_in;
   logic [IW-1:0] j_ff, j_in;
   edge_type      cur_ff, cur_in;
   edge_type      rd_ff;
   logic          done_ff, done_in;

   logic [IW-1:0] ra;
   logic          we;
   logic [IW-1:0] wa;
   edge_type      wd;

   // stable insertion sort, one shift per cycle
   always_comb begin
      st_in   = st_ff;
      i_in    = i_ff;
      j_in    = j_ff;
      cur_in  = cur_ff;
      done_in = 1'b0;
      ra      = rd_addr;
      we      = ctl.wr_en;
      wa      = wr_addr;
      wd      = wr_data;
      unique case (st_ff)
         ST_IDLE: begin
            if (ctl.sort_start) begin
               if (fill <= CW'(1)) begin
                  done_in = 1'b1;
               end else begin
                  i_in  = CW'(1);
                  st_in = ST_RDI;
               end
            end
         end
         ST_RDI: begin
            we    = 1'b0;
            ra    = i_ff[IW-1:0];
            st_in = ST_GETI;
         end
         ST_GETI: begin
            we     = 1'b0;
            cur_in = rd_ff;
            j_in   = i_ff[IW-1:0];
            ra     = i_ff[IW-1:0] - IW'(1);
            st_in  = ST_CMP;
         end
         ST_CMP: begin
            we = 1'b0;
            if ($signed(rd_ff.weight) > $signed(cur_ff.weight)) begin
               we   = 1'b1;
               wa   = j_ff;
               wd   = rd_ff;
               j_in = j_ff - IW'(1);
               ra   = j_ff - IW'(2);
               if (j_ff == IW'(1)) begin
                  st_in = ST_PLACE;
               end
            end else begin
               st_in = ST_PLACE;
            end
         end
         ST_PLACE: begin
            we   = 1'b1;
            wa   = j_ff;
            wd   = cur_ff;
            i_in = i_ff + CW'(1);
            if (i_ff + CW'(1) == fill) begin
               done_in = 1'b1;
               st_in   = ST_IDLE;
            end else begin
               st_in = ST_RDI;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_ff <= mem[ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
      i_ff   <= i_in;
      j_ff   <= j_in;
      cur_ff <= cur_in;
   end

   assign rd_data       = rd_ff;
   assign sts.sort_done = done_ff;

endmodule

@@ design/kmst_dsu.sv @@
module kmst_dsu (
   input  logic                  clock,
   input  logic                  reset,
   input  kmst_pkg::dsu_req_type req,
   output kmst_pkg::dsu_rsp_type rsp
);
   import kmst_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_FIND_RD  = 3'd1;
   localparam logic [2:0] ST_FIND_CHK = 3'd2;
   localparam logic [2:0] ST_COMP_RD  = 3'd3;
   localparam logic [2:0] ST_COMP_CHK = 3'd4;
   localparam logic [2:0] ST_LINK     = 3'd5;
   localparam logic [2:0] ST_BUMP     = 3'd6;

   typedef struct packed {
      vert_type               parent;
      logic [RANK_BITS-1:0]   rank;
   } node_type;

   node_type mem [MAX_VERTICES];

   // an entry not yet written is its own root with rank zero
   logic [MAX_VERTICES-1:0] vld_ff, vld_in;

   logic [2:0]           st_ff, st_in;
   vert_type             x_ff, x_in;
   vert_type             org_ff, org_in;
   vert_type             b_ff, b_in;
   vert_type             root_ff, root_in;
   logic [RANK_BITS-1:0] rroot_ff, rroot_in;
   vert_type             ra_ff, ra_in;
   logic [RANK_BITS-1:0] rka_ff, rka_in;
   logic                 phase_ff, phase_in;
   logic                 done_ff, done_in;
   logic                 joined_ff, joined_in;

   node_type             rd_ff;
   logic                 rd_vld_ff;
   vert_type             rd_addr_ff;
   vert_type             cur_parent;
   logic [RANK_BITS-1:0] cur_rank;

   logic                 we;
   vert_type             wa;
   node_type             wd;

   assign cur_parent = rd_vld_ff ? rd_ff.parent : rd_addr_ff;
   assign cur_rank   = rd_vld_ff ? rd_ff.rank : '0;

   always_comb begin
      st_in     = st_ff;
      x_in      = x_ff;
      org_in    = org_ff;
      b_in      = b_ff;
      root_in   = root_ff;
      rroot_in  = rroot_ff;
      ra_in     = ra_ff;
      rka_in    = rka_ff;
      phase_in  = phase_ff;
      done_in   = 1'b0;
      joined_in = 1'b0;
      vld_in    = vld_ff;
      we        = 1'b0;
      wa        = x_ff;
      wd        = '{parent: root_ff, rank: cur_rank};
      unique case (st_ff)
         ST_IDLE: begin
            if (req.clear) begin
               vld_in = '0;
            end
            if (req.start) begin
               x_in     = req.a;
               org_in   = req.a;
               b_in     = req.b;
               phase_in = 1'b0;
               st_in    = ST_FIND_RD;
            end
         end
         ST_FIND_RD: st_in = ST_FIND_CHK;
         ST_FIND_CHK: begin
            if (cur_parent == x_ff) begin
               root_in  = x_ff;
               rroot_in = cur_rank;
               x_in     = org_ff;
               st_in    = ST_COMP_RD;
            end else begin
               x_in  = cur_parent;
               st_in = ST_FIND_RD;
            end
         end
         ST_COMP_RD: st_in = ST_COMP_CHK;
         ST_COMP_CHK: begin
            if (cur_parent == root_ff) begin
               if (!phase_ff) begin
                  ra_in    = root_ff;
                  rka_in   = rroot_ff;
                  phase_in = 1'b1;
                  x_in     = b_ff;
                  org_in   = b_ff;
                  st_in    = ST_FIND_RD;
               end else begin
                  st_in = ST_LINK;
               end
            end else begin
               // path compression: point this node straight at the root
               we         = 1'b1;
               wa         = x_ff;
               wd         = '{parent: root_ff, rank: cur_rank};
               vld_in[x_ff] = 1'b1;
               x_in       = cur_parent;
               st_in      = ST_COMP_RD;
            end
         end
         ST_LINK: begin
            if (ra_ff == root_ff) begin
               done_in = 1'b1;
               st_in   = ST_IDLE;
            end else if (rka_ff < rroot_ff) begin
               we            = 1'b1;
               wa            = ra_ff;
               wd            = '{parent: root_ff, rank: rka_ff};
               vld_in[ra_ff] = 1'b1;
               done_in       = 1'b1;
               joined_in     = 1'b1;
               st_in         = ST_IDLE;
            end else begin
               we              = 1'b1;
               wa              = root_ff;
               wd              = '{parent: ra_ff, rank: rroot_ff};
               vld_in[root_ff] = 1'b1;
               if (rka_ff == rroot_ff) begin
                  st_in = ST_BUMP;
               end else begin
                  done_in   = 1'b1;
                  joined_in = 1'b1;
                  st_in     = ST_IDLE;
               end
            end
         end
         ST_BUMP: begin
            we            = 1'b1;
            wa            = ra_ff;
            wd            = '{parent: ra_ff, rank: rka_ff + RANK_BITS'(1)};
            vld_in[ra_ff] = 1'b1;
            done_in       = 1'b1;
            joined_in     = 1'b1;
            st_in         = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_ff      <= mem[x_ff];
      rd_vld_ff  <= vld_ff[x_ff];
      rd_addr_ff <= x_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= ST_IDLE;
         vld_ff    <= '0;
         done_ff   <= 1'b0;
         joined_ff <= 1'b0;
      end else begin
         st_ff     <= st_in;
         vld_ff    <= vld_in;
         done_ff   <= done_in;
         joined_ff <= joined_in;
      end
      x_ff     <= x_in;
      org_ff   <= org_in;
      b_ff     <= b_in;
      root_ff  <= root_in;
      rroot_ff <= rroot_in;
      ra_ff    <= ra_in;
      rka_ff   <= rka_in;
      phase_ff <= phase_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.joined = joined_ff;

endmodule

@@ design/kruskal_minimum_spanning_tree_top.sv @@
// Loading accepts one edge item per cycle. After the last edge, an insertion sort runs
// over the edge memory, then a scan does one union-find join per in-range edge until
// the tree is full, then the results leave one at a time, held while rsp_tready is low.
// The edge memory's single read port and the union-find sequencer pace these phases.
// Synchronous active-high reset: vertex_count becomes 64 and the block waits for edges.
module kruskal_minimum_spanning_tree_top #(
   parameter int MAX_EDGES = kmst_pkg::DEF_MAX_EDGES
) (
   input  logic                                clock,
   input  logic                                reset,
   // edge_from[5:0], edge_to[11:6], edge_weight[27:12], zero fill
   input  logic [kmst_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  logic                                req_tlast,   // last_edge
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tree_from[5:0], tree_to[11:6], tree_weight[27:12], total_weight[49:28],
   // connected[50], edges_dropped[51], zero fill
   output logic [kmst_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                                rsp_tuser,   // edge_valid
   output logic                                rsp_tlast,   // last_result
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [kmst_pkg::VC_BITS-1:0]        csr_data,    // vertex_count
   input  logic                                csr_valid,
   output logic                                csr_ready
);
   import kmst_pkg::*;

   localparam int IW = $clog2(MAX_EDGES);
   localparam int CW = $clog2(MAX_EDGES + 1);

   localparam logic [3:0] ST_LOAD       = 4'd0;
   localparam logic [3:0] ST_SORT_GO    = 4'd1;
   localparam logic [3:0] ST_SORT       = 4'd2;
   localparam logic [3:0] ST_SCAN_CHK   = 4'd3;
   localparam logic [3:0] ST_SCAN_GET   = 4'd4;
   localparam logic [3:0] ST_SCAN_JOIN  = 4'd5;
   localparam logic [3:0] ST_EMIT_START = 4'd6;
   localparam logic [3:0] ST_EMIT_RD    = 4'd7;
   localparam logic [3:0] ST_EMIT_GET   = 4'd8;
   localparam logic [3:0] ST_EMIT_HOLD  = 4'd9;

   logic [3:0]                   st_ff, st_in;
   logic [VC_BITS-1:0]           vcount_ff;
   logic [CW-1:0]                fill_ff, fill_in;
   logic [CW-1:0]                idx_ff, idx_in;
   logic [VC_BITS-1:0]           tfill_ff, tfill_in;
   logic [VC_BITS-1:0]           k_ff, k_in;
   logic                         drop_ff, drop_in;
   edge_type                     cur_ff, cur_in;
   logic signed [TOTAL_BITS-1:0] run_ff, run_in;

   // output register
   logic                         ovalid_ff, ovalid_in;
   edge_type                     oedge_ff, oedge_in;
   logic                         oev_ff, oev_in;
   logic signed [TOTAL_BITS-1:0] ototal_ff, ototal_in;
   logic                         oconn_ff, oconn_in;
   logic                         odrop_ff, odrop_in;
   logic                         olast_ff, olast_in;

   // tree store
   edge_type                     tree_mem [MAX_VERTICES];
   edge_type                     tree_rd_ff;
   logic                         tree_we;

   edge_type                     req_edge;
   logic                         req_take;
   logic [VC_BITS-1:0]           vc_eff;
   logic [VC_BITS-1:0]           vc_lim;
   logic                         req_bad;
   logic                         cur_bad;
   logic                         conn;

   est_ctl_type                  est_ctl;
   est_sts_type                  est_sts;
   edge_type                     est_rd;
   dsu_req_type                  dsu_req;
   dsu_rsp_type                  dsu_rsp;

   assign req_edge = edge_type'(req_tdata[$bits(edge_type)-1:0]);
   assign req_take = req_tvalid && req_tready;

   // vertex_count of zero acts as one, above the vertex limit it saturates
   assign vc_eff = (vcount_ff == '0) ? VC_BITS'(1) :
                   (vcount_ff > VC_BITS'(MAX_VERTICES)) ? VC_BITS'(MAX_VERTICES) : vcount_ff;
   assign vc_lim = vc_eff - VC_BITS'(1);

   assign req_bad = ({1'b0, req_edge.from_vtx} >= vc_eff) ||
                    ({1'b0, req_edge.to_vtx} >= vc_eff) ||
                    (fill_ff == CW'(MAX_EDGES));
   assign cur_bad = ({1'b0, est_rd.from_vtx} >= vc_eff) ||
                    ({1'b0, est_rd.to_vtx} >= vc_eff);
   assign conn    = (tfill_ff == vc_lim);

   always_comb begin
      st_in      = st_ff;
      fill_in    = fill_ff;
      idx_in     = idx_ff;
      tfill_in   = tfill_ff;
      k_in       = k_ff;
      drop_in    = drop_ff;
      cur_in     = cur_ff;
      run_in     = run_ff;
      ovalid_in  = ovalid_ff;
      oedge_in   = oedge_ff;
      oev_in     = oev_ff;
      ototal_in  = ototal_ff;
      oconn_in   = oconn_ff;
      odrop_in   = odrop_ff;
      olast_in   = olast_ff;
      tree_we    = 1'b0;
      est_ctl    = '0;
      dsu_req    = '{start: 1'b0, clear: 1'b0, a: cur_ff.from_vtx, b: cur_ff.to_vtx};
      unique case (st_ff)
         ST_LOAD: begin
            if (req_take) begin
               if (req_bad) begin
                  drop_in = 1'b1;
               end else begin
                  est_ctl.wr_en = 1'b1;
                  fill_in       = fill_ff + CW'(1);
               end
               if (req_tlast) begin
                  st_in = ST_SORT_GO;
               end
            end
         end
         ST_SORT_GO: begin
            est_ctl.sort_start = 1'b1;
            st_in              = ST_SORT;
         end
         ST_SORT: begin
            if (est_sts.sort_done) begin
               dsu_req.clear = 1'b1;
               idx_in        = '0;
               tfill_in      = '0;
               st_in         = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if ((idx_ff < fill_ff) && (tfill_ff < vc_lim)) begin
               st_in = ST_SCAN_GET;
            end else begin
               st_in = ST_EMIT_START;
            end
         end
         ST_SCAN_GET: begin
            cur_in = est_rd;
            if (cur_bad) begin
               // stored edge that the current vertex_count puts out of range
               drop_in = 1'b1;
               idx_in  = idx_ff + CW'(1);
               st_in   = ST_SCAN_CHK;
            end else begin
               dsu_req.start = 1'b1;
               dsu_req.a     = est_rd.from_vtx;
               dsu_req.b     = est_rd.to_vtx;
               st_in         = ST_SCAN_JOIN;
            end
         end
         ST_SCAN_JOIN: begin
            if (dsu_rsp.done) begin
               if (dsu_rsp.joined) begin
                  tree_we  = 1'b1;
                  tfill_in = tfill_ff + VC_BITS'(1);
               end
               idx_in = idx_ff + CW'(1);
               st_in  = ST_SCAN_CHK;
            end
         end
         ST_EMIT_START: begin
            k_in   = '0;
            run_in = '0;
            if (tfill_ff == '0) begin
               // empty tree: one report item, no edge
               ovalid_in = 1'b1;
               oedge_in  = '0;
               oev_in    = 1'b0;
               ototal_in = '0;
               oconn_in  = conn;
               odrop_in  = drop_ff;
               olast_in  = 1'b1;
               st_in     = ST_EMIT_HOLD;
            end else begin
               st_in = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD: st_in = ST_EMIT_GET;
         ST_EMIT_GET: begin
            run_in    = run_ff + TOTAL_BITS'(tree_rd_ff.weight);
            ovalid_in = 1'b1;
            oedge_in  = tree_rd_ff;
            oev_in    = 1'b1;
            ototal_in = run_ff + TOTAL_BITS'(tree_rd_ff.weight);
            oconn_in  = conn;
            odrop_in  = drop_ff;
            olast_in  = (k_ff + VC_BITS'(1) == tfill_ff);
            st_in     = ST_EMIT_HOLD;
         end
         ST_EMIT_HOLD: begin
            if (rsp_tready) begin
               ovalid_in = 1'b0;
               if (olast_ff) begin
                  fill_in  = '0;
                  tfill_in = '0;
                  drop_in  = 1'b0;
                  st_in    = ST_LOAD;
               end else begin
                  k_in  = k_ff + VC_BITS'(1);
                  st_in = ST_EMIT_RD;
               end
            end
         end
         default: st_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (tree_we) begin
         tree_mem[tfill_ff[VERT_BITS-1:0]] <= cur_ff;
      end
      tree_rd_ff <= tree_mem[k_ff[VERT_BITS-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= ST_LOAD;
         vcount_ff <= VC_BITS'(MAX_VERTICES);
         fill_ff   <= '0;
         tfill_ff  <= '0;
         drop_ff   <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         st_ff     <= st_in;
         fill_ff   <= fill_in;
         tfill_ff  <= tfill_in;
         drop_ff   <= drop_in;
         ovalid_ff <= ovalid_in;
         if (csr_valid && csr_ready) begin
            vcount_ff <= csr_data;
         end
      end
      idx_ff    <= idx_in;
      k_ff      <= k_in;
      cur_ff    <= cur_in;
      run_ff    <= run_in;
      oedge_ff  <= oedge_in;
      oev_ff    <= oev_in;
      ototal_ff <= ototal_in;
      oconn_ff  <= oconn_in;
      odrop_ff  <= odrop_in;
      olast_ff  <= olast_in;
   end

   kmst_estore #(
      .MAX_EDGES (MAX_EDGES)
   ) u_estore (
      .clock   (clock),
      .reset   (reset),
      .ctl     (est_ctl),
      .wr_addr (fill_ff[IW-1:0]),
      .wr_data (req_edge),
      .rd_addr (idx_ff[IW-1:0]),
      .fill    (fill_ff),
      .rd_data (est_rd),
      .sts     (est_sts)
   );

   kmst_dsu u_dsu (
      .clock (clock),
      .reset (reset),
      .req   (dsu_req),
      .rsp   (dsu_rsp)
   );

   assign req_tready = (st_ff == ST_LOAD);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tuser  = oev_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS - $bits(edge_type) - TOTAL_BITS - 2){1'b0}},
                        odrop_ff, oconn_ff, ototal_ff, oedge_ff};

endmodule

@@ design/kmst_checker.sv @@
module kmst_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               req_tlast,
   input logic [kmst_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                               rsp_tuser,
   input logic                               rsp_tlast,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready
);
   import kmst_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_tvalid && req_tready))
      else $error("input taken while results pending");

   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("still ready after last edge");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && (rsp_tdata[49:0] == '0))
      else $error("empty report malformed");

endmodule

bind kruskal_minimum_spanning_tree_top kmst_checker u_kmst_checker (.*);

@@ tb/kruskal_minimum_spanning_tree_top_tb.sv @@
module kruskal_minimum_spanning_tree_top_tb;
   import kmst_pkg::*;

   typedef struct {
      logic [5:0]         from_v;
      logic [5:0]         to_v;
      logic signed [15:0] weight;
   } graph_edge_t;

   typedef struct {
      logic [5:0]         from_v;
      logic [5:0]         to_v;
      logic signed [15:0] weight;
      logic               valid;
      logic [21:0]        total;
      logic               conn;
      logic               dropped;
      logic               last;
   } tree_item_t;

   // Keeps the graph being loaded, builds the expected tree on the last edge,
   // and checks the outgoing tree items against it.
   class mst_scoreboard;
      int          vertex_reg = 64;
      graph_edge_t graph_q[$];
      bit          drop_seen;
      tree_item_t  tree_q[$];
      int          errors;
      int          tree_items;
      int          graphs;

      function int live_vertices();
         if (vertex_reg == 0) return 1;
         if (vertex_reg > MAX_VERTICES) return MAX_VERTICES;
         return vertex_reg;
      endfunction

      function void note_edge(logic [5:0] f, logic [5:0] t, logic signed [15:0] w,
                              logic last);
         int          vc;
         graph_edge_t e;
         vc = live_vertices();
         if (f >= vc || t >= vc || graph_q.size() >= DEF_MAX_EDGES) begin
            drop_seen = 1;
         end else begin
            e.from_v = f;
            e.to_v   = t;
            e.weight = w;
            graph_q  = {graph_q, e};
         end
         if (last) build_tree();
      endfunction

      function void build_tree();
         graph_edge_t sorted[$];
         graph_edge_t cur;
         graph_edge_t picked[$];
         int          parent[MAX_VERTICES];
         int          vc, j, ra, rb, run;
         bit          conn;
         tree_item_t  r;
         vc = live_vertices();
         sorted = graph_q;
         // stable insertion sort, ties keep arrival order
         for (int i = 1; i < sorted.size(); i++) begin
            cur = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1].weight > cur.weight) begin
               sorted[j] = sorted[j-1];
               j--;
            end
            sorted[j] = cur;
         end
         for (int i = 0; i < MAX_VERTICES; i++) parent[i] = i;
         foreach (sorted[i]) begin
            if (picked.size() >= vc - 1) break;
            if (sorted[i].from_v >= vc || sorted[i].to_v >= vc) begin
               drop_seen = 1;
               continue;
            end
            ra = sorted[i].from_v;
            while (parent[ra] != ra) ra = parent[ra];
            rb = sorted[i].to_v;
            while (parent[rb] != rb) rb = parent[rb];
            if (ra != rb) begin
               parent[rb] = ra;
               picked = {picked, sorted[i]};
            end
         end
         conn = (picked.size() == vc - 1);
         r.conn    = conn;
         r.dropped = drop_seen;
         if (picked.size() == 0) begin
            r.from_v = 0; r.to_v = 0; r.weight = 0; r.valid = 0; r.total = 0;
            r.last = 1;
            tree_q = {tree_q, r};
         end else begin
            run = 0;
            foreach (picked[k]) begin
               run += picked[k].weight;
               r.from_v = picked[k].from_v;
               r.to_v   = picked[k].to_v;
               r.weight = picked[k].weight;
               r.valid  = 1;
               r.total  = run[21:0];
               r.last   = (k == picked.size() - 1);
               tree_q   = {tree_q, r};
            end
         end
         graph_q.delete();
         drop_seen = 0;
         graphs++;
      endfunction

      function void check_item(logic [RSP_DATA_BITS-1:0] d, logic user, logic last);
         tree_item_t e;
         tree_item_t a;
         a.from_v = d[5:0];   a.to_v = d[11:6];  a.weight = d[27:12];
         a.total  = d[49:28]; a.conn = d[50];    a.dropped = d[51];
         a.valid  = user;     a.last = last;
         tree_items++;
         if (tree_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected tree item: data=%h user=%b last=%b",
                                       d, user, last);
            return;
         end
         e = tree_q.pop_front();
         if (a.from_v !== e.from_v || a.to_v !== e.to_v || a.weight !== e.weight ||
             a.valid !== e.valid || a.total !== e.total || a.conn !== e.conn ||
             a.dropped !== e.dropped || a.last !== e.last) begin
            errors++;
            if (errors <= 10)
               $display("tree item %0d mismatch: exp %0d-%0d w=%0d v=%b tot=%0d c=%b d=%b l=%b",
                        tree_items, e.from_v, e.to_v, e.weight, e.valid, $signed(e.total),
                        e.conn, e.dropped, e.last);
            if (errors <= 10)
               $display("   got %0d-%0d w=%0d v=%b tot=%0d c=%b d=%b l=%b",
                        a.from_v, a.to_v, a.weight, a.valid, $signed(a.total),
                        a.conn, a.dropped, a.last);
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic                     req_tlast;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tuser;
   logic                     rsp_tlast;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [VC_BITS-1:0]       csr_data;
   logic                     csr_valid;
   logic                     csr_ready;

   mst_scoreboard sb = new();
   bit            quiet;        // no idling in the closing part of the run
   int            rsp_hold;
   int            cycle_count;
   int            edges_sent;

   localparam int CYCLE_LIMIT = 3000000;

   kruskal_minimum_spanning_tree_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // Every accepted edge item goes to the predictor, every tree item to the checker.
   // Both read the values settled before this edge's updates.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_edge(req_tdata[5:0], req_tdata[11:6], req_tdata[27:12], req_tlast);
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_item(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // Result side back-pressure: random stall bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_hold   <= 0;
         rsp_tready <= 1'b1;
      end else if (rsp_hold > 0) begin
         rsp_hold   <= rsp_hold - 1;
         rsp_tready <= (rsp_hold == 1);
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         rsp_hold   <= $urandom_range(1, 15);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[kruskal_minimum_spanning_tree_top] ERROR");
         $finish;
      end
   end

   // Write vertex_count; only called with the block idle.
   task automatic set_vertices(int v);
      csr_data  <= v[VC_BITS-1:0];
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.vertex_reg = v & 7'h7f;
   endtask

   // Drive one edge item, maybe after a random idle burst. Valid stays high
   // after acceptance so back-to-back items need no extra step.
   task automatic send_edge(int f, int t, int w, bit last);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tdata  <= {4'b0, w[15:0], t[5:0], f[5:0]};
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      edges_sent++;
   endtask

   // Wait for the whole tree to drain, then let the block settle. It first waits for
   // a clock edge, so the predictor has seen the last edge of the graph.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.tree_q.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic int pick_weight();
      if ($urandom_range(0, 2) == 0) return $urandom_range(0, 7);   // force ties
      return $urandom;
   endfunction

   initial begin
      int vc, n, f, t;
      reset       <= 1'b1;
      cycle_count <= 0;
      req_tdata   <= '0;
      req_tlast   <= 1'b0;
      req_tvalid  <= 1'b0;
      csr_data    <= '0;
      csr_valid   <= 1'b0;
      quiet = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // weight extremes, a self loop, three equal weights, all at reset count
      send_edge(0, 63, -32768, 0);
      send_edge(63, 0, 32767, 0);
      send_edge(5, 5, 100, 0);
      send_edge(1, 2, 7, 0);
      send_edge(2, 3, 7, 0);
      send_edge(1, 3, 7, 0);
      send_edge(3, 4, 0, 1);
      drain();

      // out-of-range vertex is dropped and flagged
      set_vertices(8);
      send_edge(0, 9, 1, 0);
      send_edge(1, 2, 5, 1);
      drain();
      // tree with nothing in it: a lone self loop, then a lone bad edge
      send_edge(3, 3, 4, 1);
      drain();
      send_edge(9, 1, -3, 1);
      drain();

      // single vertex, and a zero count that behaves as one
      set_vertices(1);
      send_edge(0, 0, 5, 1);
      drain();
      set_vertices(0);
      send_edge(1, 0, 2, 0);
      send_edge(0, 0, 1, 1);
      drain();

      // count above the maximum clamps to 64
      set_vertices(127);
      send_edge(63, 62, -1, 1);
      drain();

      // two vertices: the lighter of two parallel edges wins
      set_vertices(2);
      send_edge(0, 1, 3, 0);
      send_edge(1, 0, 2, 1);
      drain();

      // overfill the edge store so the last edge hits the capacity limit
      set_vertices(64);
      for (int i = 0; i < DEF_MAX_EDGES + 1; i++)
         send_edge($urandom_range(0, 63), $urandom_range(0, 63), $urandom,
                   i == DEF_MAX_EDGES);
      drain();

      // random graphs, mostly valid vertices with some strays
      vc = 64;
      for (int g = 0; g < 6; g++) begin
         quiet = (g >= 4);
         case ($urandom_range(0, 5))
            0:       vc = 64;
            1:       vc = $urandom_range(0, 1) ? 0 : 127;
            2:       vc = $urandom_range(2, 4);
            default: vc = $urandom_range(1, 64);
         endcase
         set_vertices(vc);
         n = $urandom_range(1, 12);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
               f = $urandom_range(0, 63);
               t = $urandom_range(0, 63);
            end else begin
               f = $urandom_range(0, sb.live_vertices() - 1);
               t = $urandom_range(0, sb.live_vertices() - 1);
            end
            send_edge(f, t, pick_weight(), i == n - 1);
         end
         drain();
      end

      repeat (50) @(posedge clock);
      $display("covered %0d edge items in %0d graphs, %0d tree items checked",
               edges_sent, sb.graphs, sb.tree_items);
      $display("vertex counts from 0 to 127, drops, capacity overflow, empty trees");
      if (sb.errors == 0 && sb.tree_q.size() == 0) begin
         $display("[kruskal_minimum_spanning_tree_top] OK");
      end else begin
         $display("%0d mismatches, %0d tree items still expected", sb.errors,
                  sb.tree_q.size());
         $display("[kruskal_minimum_spanning_tree_top] ERROR");
      end
      $finish;
   end

endmodule
